// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the allocator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication held on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |=> (cons), msg)

`endif

// File: rtl/core/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg
// Types, constants and helpers of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEAP_MAX_BYTES  = 65536;
   localparam int ALIGN_BYTES     = 16;
   localparam int HEADER_BYTES    = 48;
   localparam int MIN_SPLIT_BYTES = 32;
   localparam int GRANULES        = HEAP_MAX_BYTES / ALIGN_BYTES;
   localparam int GRAN_BITS       = $clog2(GRANULES);
   localparam int ALIGN_BITS      = $clog2(ALIGN_BYTES);
   localparam int OFF_BITS        = GRAN_BITS + ALIGN_BITS;

   localparam logic [17:0] HDR18   = 18'(HEADER_BYTES);
   localparam logic [17:0] SPLIT18 = 18'(HEADER_BYTES + MIN_SPLIT_BYTES);
   localparam logic [16:0] RESET_HEAP_BYTES = 17'(HEAP_MAX_BYTES);

   // One memory word per granule
   typedef struct packed {
      logic                 start;
      logic                 free;
      logic [15:0]          size;
      logic [GRAN_BITS-1:0] prev;
   } ffha_entry_type;

   localparam int ENTRY_BITS = $bits(ffha_entry_type);

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_NO_FIT   = 3'd1,
      STS_OUTSIDE  = 3'd2,
      STS_MISALIGN = 3'd3,
      STS_BAD_HDR  = 3'd4,
      STS_DBL_FREE = 3'd5
   } ffha_status_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_WALK_RD, S_WALK_EV, S_SPLIT, S_SPLIT_AFTER, S_SPLIT_NEW,
      S_SPLIT_BASE, S_FREE_RD, S_FREE_EV, S_MRG_NEXT, S_MRG_EVAL, S_MRG_AFTER,
      S_MRG_CLEAR, S_MRG_END, S_PREV_RD, S_PREV_EV, S_DONE
   } ffha_state_type;

   typedef struct packed {
      logic            valid;
      ffha_status_type status;
      logic [15:0]     granted;
   } ffha_result_type;

   // Usable heap end from a size register write, zero when no heap fits
   function automatic logic [16:0] heap_end_of(input logic [16:0] bytes);
      logic [16:0] clamped;
      clamped = (bytes > RESET_HEAP_BYTES) ? RESET_HEAP_BYTES : bytes;
      clamped[ALIGN_BITS-1:0] = '0;
      if ({1'b0, clamped} <= SPLIT18) begin
         return '0;
      end
      return clamped;
   endfunction

endpackage

// File: rtl/core/first_fit_heap_allocator_core.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with block splitting and coalescing on free.
// ---------------------------------------------------------------------------
// One request is in work at a time. Block state sits in a 4096-entry memory
// with one read and one write port, one word per 16-byte granule. An
// allocate walks the blocks first-fit, then splits and marks the chosen
// block; a free reads the block header, merges each free neighbor that
// follows, then reads the previous block, if any, and merges with it when
// it is free. A free that fails on the header or hits a free block ends
// after the header read. Checks that fail on the offset alone need no
// memory access. After reset and after every heap size write, a clearing
// pass sweeps the whole memory before requests are accepted. The result
// sits in an output register, so the next request is taken while it waits.
module first_fit_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // request_bytes[16:0], payload_offset[32:17], zero pad
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // status[2:0], granted_offset[18:3], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   ffha_pkg::ffha_result_type result;
   logic                      result_take;
   logic                      rsp_valid_ff;
   ffha_pkg::ffha_status_type rsp_status_ff;
   logic [15:0]               rsp_granted_ff;
   logic                      mem_wr_en, mem_rd_en;
   logic [ffha_pkg::GRAN_BITS-1:0] mem_wr_addr, mem_rd_addr;
   ffha_pkg::ffha_entry_type  mem_wr_data, mem_rd_data;

   ffha_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_go         (req_tvalid && req_tready),
      .opcode         (req_tuser),
      .request_bytes  (req_tdata[16:0]),
      .payload_offset (req_tdata[32:17]),
      .csr_go         (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .req_ready      (req_tready),
      .csr_ready      (csr_ready),
      .result         (result),
      .result_take    (result_take),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   ffha_ram #(
      .WIDTH (ffha_pkg::ENTRY_BITS),
      .DEPTH (ffha_pkg::GRANULES)
   ) u_blocks (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Load the output register when it is empty or being drained
   assign result_take = result.valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result_take) begin
         rsp_status_ff  <= result.status;
         rsp_granted_ff <= result.granted;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_granted_ff, rsp_status_ff};

endmodule

// File: rtl/core/ffha_ram.sv
// ---------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ffha_ctrl.sv
// ---------------------------------------------------------------------------
// ffha_ctrl
// Sequencer that walks, splits, frees and merges blocks in the block memory.
// ---------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_go,
   input  logic                               opcode,
   input  logic [16:0]                        request_bytes,
   input  logic [15:0]                        payload_offset,
   input  logic                               csr_go,
   input  logic [16:0]                        csr_data,
   output logic                               req_ready,
   output logic                               csr_ready,
   output ffha_pkg::ffha_result_type          result,
   input  logic                               result_take,
   output logic                               mem_wr_en,
   output logic [ffha_pkg::GRAN_BITS-1:0]     mem_wr_addr,
   output ffha_pkg::ffha_entry_type           mem_wr_data,
   output logic                               mem_rd_en,
   output logic [ffha_pkg::GRAN_BITS-1:0]     mem_rd_addr,
   input  ffha_pkg::ffha_entry_type           mem_rd_data
);

   localparam int GB = ffha_pkg::GRAN_BITS;
   localparam int AB = ffha_pkg::ALIGN_BITS;

   ffha_pkg::ffha_state_type  state_ff, state_in;
   logic [GB-1:0]             clr_ff, clr_in;
   logic [16:0]               heap_end_ff, heap_end_in;
   logic [15:0]               cur_ff, cur_in;
   ffha_pkg::ffha_entry_type  ent_ff, ent_in;
   logic [17:0]               wanted_ff, wanted_in;
   ffha_pkg::ffha_status_type status_ff, status_in;
   logic [15:0]               granted_ff, granted_in;
   logic [15:0]               boff_ff, boff_in;
   ffha_pkg::ffha_entry_type  bent_ff, bent_in;
   logic [15:0]               nx_ff, nx_in;
   logic [15:0]               aft_ff, aft_in;
   logic                      split_ff, split_in;
   logic                      second_ff, second_in;

   ffha_pkg::ffha_entry_type  rd;
   logic [17:0] heap18, walk_n, sp_nb, sp_after, m_nx, m_after;
   logic        fit, sp_do, sp_after_in, m_ok;
   logic [GB-1:0] sp_ng;
   logic [17:0] wanted_calc;
   logic        f_outside, f_misalign, f_bad;

   // Shared address arithmetic
   always_comb begin
      rd          = mem_rd_data;
      heap18      = {1'b0, heap_end_ff};
      fit         = rd.free && ({2'b0, rd.size} >= wanted_ff);
      walk_n      = {2'b0, cur_ff} + ffha_pkg::HDR18 + {2'b0, rd.size};
      sp_nb       = {2'b0, cur_ff} + ffha_pkg::HDR18 + wanted_ff;
      sp_after    = {2'b0, cur_ff} + ffha_pkg::HDR18 + {2'b0, ent_ff.size};
      sp_do       = ({2'b0, ent_ff.size} > (wanted_ff + ffha_pkg::SPLIT18)) &&
                    ((sp_nb + ffha_pkg::HDR18) < heap18);
      sp_after_in = sp_after < heap18;
      sp_ng       = sp_nb[AB +: GB];
      m_nx        = {2'b0, boff_ff} + ffha_pkg::HDR18 + {2'b0, bent_ff.size};
      m_ok        = rd.start && rd.free;
      m_after     = {2'b0, nx_ff} + ffha_pkg::HDR18 + {2'b0, rd.size};
      wanted_calc = {1'b0, request_bytes} + 18'(ffha_pkg::ALIGN_BYTES - 1);
      wanted_calc[AB-1:0] = '0;
      f_outside   = (heap_end_ff == '0) || ({1'b0, payload_offset} >= heap_end_ff);
      f_misalign  = payload_offset[AB-1:0] != '0;
      f_bad       = {2'b0, payload_offset} < ffha_pkg::HDR18;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffha_pkg::S_CLEAR: begin
            if (csr_go) state_in = ffha_pkg::S_CLEAR;
            else if (clr_ff == '1) state_in = ffha_pkg::S_IDLE;
         end
         ffha_pkg::S_IDLE: begin
            if (csr_go) begin
               state_in = ffha_pkg::S_CLEAR;
            end else if (req_go) begin
               if (!opcode) begin
                  if (request_bytes == '0 || heap_end_ff == '0) state_in = ffha_pkg::S_DONE;
                  else state_in = ffha_pkg::S_WALK_RD;
               end else if (payload_offset == '0 || f_outside || f_misalign || f_bad) begin
                  state_in = ffha_pkg::S_DONE;
               end else begin
                  state_in = ffha_pkg::S_FREE_RD;
               end
            end
         end
         ffha_pkg::S_WALK_RD: state_in = ffha_pkg::S_WALK_EV;
         ffha_pkg::S_WALK_EV: begin
            if (!rd.start) state_in = ffha_pkg::S_DONE;
            else if (fit) state_in = ffha_pkg::S_SPLIT;
            else if (walk_n >= heap18) state_in = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_SPLIT: begin
            if (!sp_do) state_in = ffha_pkg::S_SPLIT_BASE;
            else if (sp_after_in) state_in = ffha_pkg::S_SPLIT_AFTER;
            else state_in = ffha_pkg::S_SPLIT_NEW;
         end
         ffha_pkg::S_SPLIT_AFTER: state_in = ffha_pkg::S_SPLIT_NEW;
         ffha_pkg::S_SPLIT_NEW:   state_in = ffha_pkg::S_SPLIT_BASE;
         ffha_pkg::S_SPLIT_BASE:  state_in = ffha_pkg::S_DONE;
         ffha_pkg::S_FREE_RD:     state_in = ffha_pkg::S_FREE_EV;
         ffha_pkg::S_FREE_EV: begin
            if (!rd.start || rd.free) state_in = ffha_pkg::S_DONE;
            else state_in = ffha_pkg::S_MRG_NEXT;
         end
         ffha_pkg::S_MRG_NEXT: begin
            if (m_nx < heap18) state_in = ffha_pkg::S_MRG_EVAL;
            else state_in = ffha_pkg::S_MRG_END;
         end
         ffha_pkg::S_MRG_EVAL: begin
            if (!m_ok) state_in = ffha_pkg::S_MRG_END;
            else if (m_after < heap18) state_in = ffha_pkg::S_MRG_AFTER;
            else state_in = ffha_pkg::S_MRG_CLEAR;
         end
         ffha_pkg::S_MRG_AFTER: state_in = ffha_pkg::S_MRG_CLEAR;
         ffha_pkg::S_MRG_CLEAR: state_in = ffha_pkg::S_MRG_NEXT;
         ffha_pkg::S_MRG_END: begin
            if (!second_ff && cur_ff != '0) state_in = ffha_pkg::S_PREV_RD;
            else state_in = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_PREV_RD: state_in = ffha_pkg::S_PREV_EV;
         ffha_pkg::S_PREV_EV: begin
            if (rd.free && rd.start) state_in = ffha_pkg::S_MRG_NEXT;
            else state_in = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_DONE: begin
            if (result_take) state_in = ffha_pkg::S_IDLE;
         end
         default: state_in = ffha_pkg::S_IDLE;
      endcase
   end

   // Datapath register updates
   always_comb begin
      clr_in      = clr_ff;
      heap_end_in = heap_end_ff;
      cur_in      = cur_ff;
      ent_in      = ent_ff;
      wanted_in   = wanted_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      boff_in     = boff_ff;
      bent_in     = bent_ff;
      nx_in       = nx_ff;
      aft_in      = aft_ff;
      split_in    = split_ff;
      second_in   = second_ff;
      if (csr_go) begin
         heap_end_in = ffha_pkg::heap_end_of(csr_data);
         clr_in      = '0;
      end else begin
         case (state_ff)
            ffha_pkg::S_CLEAR: clr_in = clr_ff + 1'b1;
            ffha_pkg::S_IDLE: begin
               if (req_go) begin
                  granted_in = '0;
                  second_in  = 1'b0;
                  wanted_in  = wanted_calc;
                  cur_in     = '0;
                  if (!opcode) begin
                     status_in = ffha_pkg::STS_NO_FIT;
                  end else begin
                     cur_in = payload_offset - 16'(ffha_pkg::HEADER_BYTES);
                     if (payload_offset == '0) status_in = ffha_pkg::STS_OK;
                     else if (f_outside) status_in = ffha_pkg::STS_OUTSIDE;
                     else if (f_misalign) status_in = ffha_pkg::STS_MISALIGN;
                     else if (f_bad) status_in = ffha_pkg::STS_BAD_HDR;
                     else status_in = ffha_pkg::STS_OK;
                  end
               end
            end
            ffha_pkg::S_WALK_EV: begin
               if (rd.start && fit) begin
                  ent_in     = rd;
                  status_in  = ffha_pkg::STS_OK;
                  granted_in = cur_ff + 16'(ffha_pkg::HEADER_BYTES);
               end else begin
                  cur_in = walk_n[15:0];
               end
            end
            ffha_pkg::S_SPLIT: begin
               split_in = sp_do;
               aft_in   = sp_after[15:0];
            end
            ffha_pkg::S_FREE_EV: begin
               if (!rd.start) begin
                  status_in = ffha_pkg::STS_BAD_HDR;
               end else if (rd.free) begin
                  status_in = ffha_pkg::STS_DBL_FREE;
               end else begin
                  bent_in      = rd;
                  bent_in.free = 1'b1;
                  boff_in      = cur_ff;
               end
            end
            ffha_pkg::S_MRG_NEXT: nx_in = m_nx[15:0];
            ffha_pkg::S_MRG_EVAL: begin
               if (m_ok) begin
                  bent_in.size = bent_ff.size + 16'(ffha_pkg::HEADER_BYTES) + rd.size;
                  aft_in       = m_after[15:0];
               end
            end
            ffha_pkg::S_PREV_EV: begin
               if (rd.free && rd.start) begin
                  bent_in   = rd;
                  boff_in   = {bent_ff.prev, {AB{1'b0}}};
                  second_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Memory ports and handshake outputs
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      req_ready   = (state_ff == ffha_pkg::S_IDLE) && !csr_go;
      csr_ready   = (state_ff == ffha_pkg::S_IDLE) || (state_ff == ffha_pkg::S_CLEAR);
      result.valid   = (state_ff == ffha_pkg::S_DONE);
      result.status  = status_ff;
      result.granted = granted_ff;
      case (state_ff)
         ffha_pkg::S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            if (clr_ff == '0 && heap_end_ff != '0) begin
               mem_wr_data.start = 1'b1;
               mem_wr_data.free  = 1'b1;
               mem_wr_data.size  = 16'(heap_end_ff - 17'(ffha_pkg::HEADER_BYTES));
            end
         end
         ffha_pkg::S_WALK_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cur_ff[AB +: GB];
         end
         ffha_pkg::S_WALK_EV: begin
            mem_rd_en   = rd.start && !fit;
            mem_rd_addr = walk_n[AB +: GB];
         end
         ffha_pkg::S_SPLIT: begin
            mem_rd_en   = sp_do && sp_after_in;
            mem_rd_addr = sp_after[AB +: GB];
         end
         ffha_pkg::S_SPLIT_AFTER: begin
            mem_wr_en        = rd.start;
            mem_wr_addr      = aft_ff[AB +: GB];
            mem_wr_data      = rd;
            mem_wr_data.prev = sp_ng;
         end
         ffha_pkg::S_SPLIT_NEW: begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = sp_ng;
            mem_wr_data.start = 1'b1;
            mem_wr_data.free  = 1'b1;
            mem_wr_data.size  = ent_ff.size - wanted_ff[15:0] - 16'(ffha_pkg::HEADER_BYTES);
            mem_wr_data.prev  = cur_ff[AB +: GB];
         end
         ffha_pkg::S_SPLIT_BASE: begin
            mem_wr_en        = 1'b1;
            mem_wr_addr      = cur_ff[AB +: GB];
            mem_wr_data      = ent_ff;
            mem_wr_data.free = 1'b0;
            if (split_ff) mem_wr_data.size = wanted_ff[15:0];
         end
         ffha_pkg::S_FREE_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cur_ff[AB +: GB];
         end
         ffha_pkg::S_MRG_NEXT: begin
            mem_rd_en   = m_nx < heap18;
            mem_rd_addr = m_nx[AB +: GB];
         end
         ffha_pkg::S_MRG_EVAL: begin
            mem_rd_en   = m_ok && (m_after < heap18);
            mem_rd_addr = m_after[AB +: GB];
         end
         ffha_pkg::S_MRG_AFTER: begin
            mem_wr_en        = rd.start;
            mem_wr_addr      = aft_ff[AB +: GB];
            mem_wr_data      = rd;
            mem_wr_data.prev = boff_ff[AB +: GB];
         end
         ffha_pkg::S_MRG_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = nx_ff[AB +: GB];
         end
         ffha_pkg::S_MRG_END: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = boff_ff[AB +: GB];
            mem_wr_data = bent_ff;
         end
         ffha_pkg::S_PREV_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = bent_ff.prev;
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ffha_pkg::S_CLEAR;
         clr_ff      <= '0;
         heap_end_ff <= ffha_pkg::heap_end_of(ffha_pkg::RESET_HEAP_BYTES);
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         heap_end_ff <= heap_end_in;
      end
      cur_ff     <= cur_in;
      ent_ff     <= ent_in;
      wanted_ff  <= wanted_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      boff_ff    <= boff_in;
      bent_ff    <= bent_in;
      nx_ff      <= nx_in;
      aft_ff     <= aft_in;
      split_ff   <= split_in;
      second_ff  <= second_in;
   end

endmodule

// File: rtl/core/ffha_checker.sv
// ---------------------------------------------------------------------------
// ffha_props
// Port-level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ffha_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready
);

   logic [2:0]  rsp_status;
   logic [15:0] rsp_granted;

   // Split the response beat into its fields
   assign rsp_status  = rsp_tdata[2:0];
   assign rsp_granted = rsp_tdata[18:3];

   // Hold a result until it is taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")

   // One request in work at a time
   `ASSERT_NEXT(a_one_req, clock, reset, req_tvalid && req_tready, !req_tready, "request overlap")

   // A size write starts the clearing pass
   `ASSERT_NEXT(a_csr_clear, clock, reset, csr_valid && csr_ready, !req_tready, "no clear pass")

   // Status codes stay in range
   `ASSERT_CLK(a_status, clock, reset, rsp_tvalid |-> (rsp_status <= ffha_pkg::STS_DBL_FREE), "bad status")

   // A failed request grants nothing
   `ASSERT_CLK(a_fail_zero, clock, reset, (rsp_tvalid && rsp_status != ffha_pkg::STS_OK) |-> (rsp_granted == '0), "grant on failure")

endmodule

bind first_fit_heap_allocator_core ffha_props u_ffha_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
